FILE: rtl/qvr_pkg.sv
package qvr_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd3;

  // Scalar part resets to one in Q2.30.
  localparam logic [CFG_DATA_W-1:0] QUAT_W_RST = 32'h4000_0000;

  // Input kind codes.
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_INVERSE = 1'b1;

  // Arithmetic widths through the pipeline.
  localparam int ACC_W     = 100;
  localparam int RND_SHIFT = 60;
  localparam int RND_W     = 40;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);

  typedef logic signed [31:0]      comp_t;  // vector component or quaternion register
  typedef logic signed [32:0]      coef_t;  // quaternion component with sign applied
  typedef logic signed [64:0]      tval_t;  // one component of p * v
  typedef logic signed [65:0]      part_t;  // half-word partial product of t * r
  typedef logic signed [67:0]      psum_t;  // sum of four partial products
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [RND_W-1:0] rnd_t;

  // Load strobes of the pipeline stages, shared by the lanes.
  typedef struct packed {
    logic acc;   // input registers
    logic prod;  // p * v products
    logic tsum;  // p * v sums
    logic part;  // t * r partial products
    logic psum;  // partial product sums
    logic rnd;   // rounded result
    logic outp;  // saturated output register
  } pipe_ctl_t;

endpackage

FILE: rtl/qvr_in_if.sv
interface qvr_in_if;
  import qvr_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  comp_t vec_x;
  comp_t vec_y;
  comp_t vec_z;

  modport source (output valid, output kind, output vec_x, output vec_y, output vec_z,
                  input ready);
  modport sink   (input valid, input kind, input vec_x, input vec_y, input vec_z,
                  output ready);
endinterface

FILE: rtl/qvr_out_if.sv
interface qvr_out_if;
  import qvr_pkg::*;

  logic  valid;
  logic  ready;
  comp_t rot_x;
  comp_t rot_y;
  comp_t rot_z;
  logic  overflow;

  modport source (output valid, output rot_x, output rot_y, output rot_z, output overflow,
                  input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, input overflow,
                  output ready);
endinterface

FILE: rtl/qvr_tlane.sv
module qvr_tlane (
  input  logic                clk,
  input  qvr_pkg::pipe_ctl_t  ctl,
  input  qvr_pkg::coef_t      coef [3],
  input  qvr_pkg::comp_t      vec  [3],
  output qvr_pkg::tval_t      t
);
  import qvr_pkg::*;

  tval_t prod_r [3];
  tval_t t_r;

  always_ff @(posedge clk) begin
    if (ctl.prod) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= coef[i] * vec[i];
      end
    end
  end

  // Three products of at most 2^62 each cannot overflow 65 bits.
  always_ff @(posedge clk) begin
    if (ctl.tsum) begin
      t_r <= prod_r[0] + prod_r[1] + prod_r[2];
    end
  end

  assign t = t_r;

endmodule

FILE: rtl/qvr_rlane.sv
module qvr_rlane (
  input  logic                clk,
  input  qvr_pkg::pipe_ctl_t  ctl,
  input  qvr_pkg::tval_t      t    [4],
  input  qvr_pkg::coef_t      coef [4],
  output qvr_pkg::rnd_t       rnd
);
  import qvr_pkg::*;

  part_t hi_r [4];
  part_t lo_r [4];
  psum_t hsum_r;
  psum_t lsum_r;
  rnd_t  rnd_r;
  acc_t  acc_nxt;

  // Each 65-bit t is cut into a signed upper half and an unsigned lower word.
  always_ff @(posedge clk) begin
    if (ctl.part) begin
      for (int i = 0; i < 4; i++) begin
        hi_r[i] <= $signed(t[i][64:32]) * coef[i];
        lo_r[i] <= $signed({1'b0, t[i][31:0]}) * coef[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.psum) begin
      hsum_r <= psum_t'(hi_r[0]) + psum_t'(hi_r[1]) + psum_t'(hi_r[2]) + psum_t'(hi_r[3]);
      lsum_r <= psum_t'(lo_r[0]) + psum_t'(lo_r[1]) + psum_t'(lo_r[2]) + psum_t'(lo_r[3]);
    end
  end

  // Round half up once on the exact product, then drop to Q16.15.
  always_comb begin
    acc_nxt = (acc_t'(hsum_r) <<< 32) + acc_t'(lsum_r) + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (ctl.rnd) begin
      rnd_r <= RND_W'(acc_nxt >>> RND_SHIFT);
    end
  end

  assign rnd = rnd_r;

endmodule

FILE: rtl/qvr_merge.sv
module qvr_merge (
  input  logic                clk,
  input  qvr_pkg::pipe_ctl_t  ctl,
  input  qvr_pkg::rnd_t       rnd [3],
  output qvr_pkg::comp_t      rot [3],
  output logic                overflow
);
  import qvr_pkg::*;

  comp_t rot_r [3];
  logic  overflow_r;
  comp_t sat_nxt [3];
  logic  [2:0] clip;

  // A component fits when bit 31 and all bits above it equal the sign bit.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      clip[i] = !((&rnd[i][RND_W-1:31]) || !(|rnd[i][RND_W-1:31]));
      if (!clip[i]) begin
        sat_nxt[i] = rnd[i][31:0];
      end else if (rnd[i][RND_W-1]) begin
        sat_nxt[i] = {1'b1, {31{1'b0}}};
      end else begin
        sat_nxt[i] = {1'b0, {31{1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.outp) begin
      rot_r      <= sat_nxt;
      overflow_r <= |clip;
    end
  end

  assign rot      = rot_r;
  assign overflow = overflow_r;

endmodule

FILE: rtl/quaternion_vector_rotation.sv
// Channel   Direction  Transfer when        Payload
// in_ch     sink       valid && ready       kind, vec_x, vec_y, vec_z
// out_ch    source     valid && ready       rot_x, rot_y, rot_z, overflow
// cfg_*     sink       cfg_we               cfg_idx selects quat_x/y/z/w, cfg_data
//
// One vector per cycle until a stall on out_ch fills the pipeline.
// The pipeline has an input register, two stages for p * v,
// three stages for the split t * r products, sums and rounding, then saturation.
// Synchronous active-low reset empties the pipeline and sets q to the identity.
// A stall on out_ch fills empty stages first; in_ch.ready drops only when all are full.
module quaternion_vector_rotation (
  input  logic                             clk,
  input  logic                             rst_n,
  qvr_in_if.sink                           in_ch,
  qvr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qvr_pkg::*;

  localparam int NUM_STG = 6;

  comp_t     quat_r [4];
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic      out_vld_r;
  logic      out_vld_nxt;
  logic [NUM_STG:0] rdy;
  pipe_ctl_t ctl;

  logic      kind_s0_r;
  logic      kind_s1_r;
  comp_t     vec_r [3];
  coef_t     tc_r  [4][3];
  coef_t     tc_nxt [4][3];
  coef_t     rc_r  [3][4];
  coef_t     rc_nxt [3][4];

  coef_t     qe [4];
  coef_t     pp [3];
  coef_t     pn [3];
  coef_t     rp [3];
  coef_t     rn [3];

  comp_t     tvec [4][3];
  tval_t     t    [4];
  tval_t     tsel [3][4];
  rnd_t      rnd  [3];
  comp_t     rot  [3];
  logic      overflow;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[0] <= '0;
      quat_r[1] <= '0;
      quat_r[2] <= '0;
      quat_r[3] <= QUAT_W_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUAT_X: quat_r[0] <= cfg_data;
        REG_QUAT_Y: quat_r[1] <= cfg_data;
        REG_QUAT_Z: quat_r[2] <= cfg_data;
        REG_QUAT_W: quat_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage takes new data when it is empty or its successor moves.
  always_comb begin
    rdy[NUM_STG] = !out_vld_r || out_ch.ready;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    out_vld_nxt = rdy[NUM_STG] ? vld_r[NUM_STG-1] : out_vld_r;

    ctl.acc  = in_ch.valid && rdy[0];
    ctl.prod = vld_r[0] && rdy[1];
    ctl.tsum = vld_r[1] && rdy[2];
    ctl.part = vld_r[2] && rdy[3];
    ctl.psum = vld_r[3] && rdy[4];
    ctl.rnd  = vld_r[4] && rdy[5];
    ctl.outp = vld_r[5] && rdy[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Signed quaternion coefficients. Negation is done at 33 bits so the most
  // negative register value turns into +2.0 without wrapping.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qe[k] = coef_t'(quat_r[k]);
    end
    for (int k = 0; k < 3; k++) begin
      pp[k] = (in_ch.kind == KIND_INVERSE) ? qe[k] : -qe[k];
      pn[k] = -pp[k];
      rp[k] = (kind_s1_r == KIND_INVERSE) ? -qe[k] : qe[k];
      rn[k] = -rp[k];
    end

    tc_nxt[0] = '{pp[1], pn[2], qe[3]};
    tc_nxt[1] = '{pn[0], pp[2], qe[3]};
    tc_nxt[2] = '{pp[0], pn[1], qe[3]};
    tc_nxt[3] = '{pn[0], pn[1], pn[2]};

    rc_nxt[0] = '{rp[0], rn[1], rp[2], qe[3]};
    rc_nxt[1] = '{rp[0], rp[1], rn[2], qe[3]};
    rc_nxt[2] = '{rn[0], rp[1], rp[2], qe[3]};
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      kind_s0_r <= in_ch.kind;
      vec_r[0]  <= in_ch.vec_x;
      vec_r[1]  <= in_ch.vec_y;
      vec_r[2]  <= in_ch.vec_z;
      tc_r      <= tc_nxt;
    end
    if (ctl.prod) begin
      kind_s1_r <= kind_s0_r;
    end
    if (ctl.tsum) begin
      rc_r <= rc_nxt;
    end
  end

  assign in_ch.ready = rdy[0];

  // Operand order of the four p * v lanes.
  always_comb begin
    tvec[0] = '{vec_r[2], vec_r[1], vec_r[0]};
    tvec[1] = '{vec_r[2], vec_r[0], vec_r[1]};
    tvec[2] = '{vec_r[1], vec_r[0], vec_r[2]};
    tvec[3] = '{vec_r[0], vec_r[1], vec_r[2]};
  end

  for (genvar g = 0; g < 4; g++) begin : g_tlane
    qvr_tlane u_tlane (
      .clk  (clk),
      .ctl  (ctl),
      .coef (tc_r[g]),
      .vec  (tvec[g]),
      .t    (t[g])
    );
  end

  // Hamilton product order for the x, y and z lanes.
  always_comb begin
    tsel[0] = '{t[3], t[2], t[1], t[0]};
    tsel[1] = '{t[2], t[3], t[0], t[1]};
    tsel[2] = '{t[1], t[0], t[3], t[2]};
  end

  for (genvar g = 0; g < 3; g++) begin : g_rlane
    qvr_rlane u_rlane (
      .clk  (clk),
      .ctl  (ctl),
      .t    (tsel[g]),
      .coef (rc_r[g]),
      .rnd  (rnd[g])
    );
  end

  qvr_merge u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .rnd      (rnd),
    .rot      (rot),
    .overflow (overflow)
  );

  assign out_ch.valid    = out_vld_r;
  assign out_ch.rot_x    = rot[0];
  assign out_ch.rot_y    = rot[1];
  assign out_ch.rot_z    = rot[2];
  assign out_ch.overflow = overflow;

  // Input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> ((&vld_r) && out_vld_r))
    else $error("input stalled with an empty pipeline stage");

  // An item in the last stage is never dropped while the output is blocked.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_STG-1] && !rdy[NUM_STG]) |=> vld_r[NUM_STG-1])
    else $error("item lost in front of the output register");

  // A result taken with nothing behind it leaves the output empty.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ch.ready && !vld_r[NUM_STG-1]) |=> !out_vld_r)
    else $error("result repeated after its transfer");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0) && !out_vld_r)
    else $error("pipeline not empty after reset");

endmodule

FILE: tb/quaternion_vector_rotation_tb.sv
`timescale 1ns / 1ps

module quaternion_vector_rotation_tb;
  import qvr_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic  kind;
    comp_t vec_x;
    comp_t vec_y;
    comp_t vec_z;
  } vec_item_t;

  typedef struct packed {
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
    logic  overflow;
  } rot_result_t;

  localparam wide_t ROUND_HALF = wide_t'(1) << 59;
  localparam wide_t COMP_MAX   = wide_t'(32'sh7FFF_FFFF);
  localparam wide_t COMP_MIN   = wide_t'(32'sh8000_0000);
  localparam comp_t Q_ONE      = 32'sh4000_0000;
  localparam comp_t C_MAX      = 32'sh7FFF_FFFF;
  localparam comp_t C_MIN      = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  qvr_in_if  in_ch();
  qvr_out_if out_ch();

  quaternion_vector_rotation dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Attitude quaternion as the block should currently hold it.
  comp_t att_x, att_y, att_z, att_w;

  vec_item_t   vectors_to_send[$];
  rot_result_t rotations_due[$];

  int send_gap;
  int recv_stall;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rounds a 2^-75 sum to Q16.15 and clamps it; bit 32 flags a clamp.
  function automatic logic [32:0] round_sat(input wide_t acc);
    wide_t r;
    r = (acc + ROUND_HALF) >>> 60;
    if (r > COMP_MAX) return {1'b1, C_MAX};
    if (r < COMP_MIN) return {1'b1, C_MIN};
    return {1'b0, r[31:0]};
  endfunction

  function automatic rot_result_t rotate_vector(input logic kind, input comp_t vx,
                                                input comp_t vy, input comp_t vz);
    wide_t a0, a1, a2, qx, qy, qz, qw;
    wide_t p0, p1, p2, p3, r0, r1, r2, r3;
    wide_t t0, t1, t2, t3;
    logic [32:0] sx, sy, sz;
    rot_result_t res;
    a0 = vx; a1 = vy; a2 = vz;
    qx = att_x; qy = att_y; qz = att_z; qw = att_w;
    // The conjugate goes on the left for frame conversion, on the right otherwise.
    if (kind == KIND_FRAME) begin
      p0 = -qx; p1 = -qy; p2 = -qz; p3 = qw;
      r0 = qx;  r1 = qy;  r2 = qz;  r3 = qw;
    end else begin
      p0 = qx;  p1 = qy;  p2 = qz;  p3 = qw;
      r0 = -qx; r1 = -qy; r2 = -qz; r3 = qw;
    end
    t0 = p1 * a2 - p2 * a1 + p3 * a0;
    t1 = -(p0 * a2) + p2 * a0 + p3 * a1;
    t2 = p0 * a1 - p1 * a0 + p3 * a2;
    t3 = -(p0 * a0) - p1 * a1 - p2 * a2;
    sx = round_sat(t3 * r0 - t2 * r1 + t1 * r2 + t0 * r3);
    sy = round_sat(t2 * r0 + t3 * r1 - t0 * r2 + t1 * r3);
    sz = round_sat(-(t1 * r0) + t0 * r1 + t3 * r2 + t2 * r3);
    res.rot_x    = sx[31:0];
    res.rot_y    = sy[31:0];
    res.rot_z    = sz[31:0];
    res.overflow = sx[32] | sy[32] | sz[32];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic comp_t pick_extreme(input comp_t unit);
    case ($urandom_range(0, 5))
      0: return C_MAX;
      1: return C_MIN;
      2: return 32'sd0;
      3: return unit;
      4: return -unit;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic comp_t random_vec_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return pick_extreme(32'sd32768);
    endcase
  endfunction

  function automatic comp_t random_quat_comp(input int style);
    int s;
    s = (style == 3) ? $urandom_range(0, 2) : style;
    case (s)
      0: return $urandom;
      // Components within +-0.5 keep the squared norm at or below one.
      1: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      default: return pick_extreme(Q_ONE);
    endcase
  endfunction

  task automatic load_quat_reg(input logic [CFG_IDX_W-1:0] idx, input comp_t val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_QUAT_X: att_x = val;
      REG_QUAT_Y: att_y = val;
      REG_QUAT_Z: att_z = val;
      REG_QUAT_W: att_w = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_attitude(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
    load_quat_reg(REG_QUAT_W, w);
    load_quat_reg(REG_QUAT_X, x);
    load_quat_reg(REG_QUAT_Z, z);
    load_quat_reg(REG_QUAT_Y, y);
  endtask

  task automatic queue_vector(input logic kind, input comp_t x, input comp_t y, input comp_t z);
    vec_item_t item;
    item.kind  = kind;
    item.vec_x = x;
    item.vec_y = y;
    item.vec_z = z;
    vectors_to_send.push_back(item);
  endtask

  // Blocks until every queued vector has been sent and every rotation checked.
  task automatic wait_drained();
    while (vectors_to_send.size() != 0 || rotations_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rotations_due.push_back(rotate_vector(in_ch.kind, in_ch.vec_x, in_ch.vec_y,
                                              in_ch.vec_z));
        vectors_to_send.delete(0);
        if ($urandom_range(0, 99) < send_idle_pct) send_gap = idle_length();
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap == 0 && vectors_to_send.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.kind  <= vectors_to_send[0].kind;
          in_ch.vec_x <= vectors_to_send[0].vec_x;
          in_ch.vec_y <= vectors_to_send[0].vec_y;
          in_ch.vec_z <= vectors_to_send[0].vec_z;
        end else begin
          in_ch.valid <= 1'b0;
          if (send_gap != 0) send_gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    rot_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rotations_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected rotation x=%h y=%h z=%h ovf=%b", $realtime,
                     out_ch.rot_x, out_ch.rot_y, out_ch.rot_z, out_ch.overflow);
        end else begin
          want = rotations_due.pop_front();
          if (out_ch.rot_x !== want.rot_x || out_ch.rot_y !== want.rot_y ||
              out_ch.rot_z !== want.rot_z || out_ch.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: rotation mismatch exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                       $realtime, want.rot_x, want.rot_y, want.rot_z, want.overflow,
                       out_ch.rot_x, out_ch.rot_y, out_ch.rot_z, out_ch.overflow);
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < recv_idle_pct) recv_stall = idle_length();
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int style;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_QUAT_X;
    cfg_data = '0;
    att_x = '0;
    att_y = '0;
    att_z = '0;
    att_w = QUAT_W_RST;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Identity quaternion straight out of reset passes vectors through.
    queue_vector(KIND_FRAME, 32'sd0, 32'sd0, 32'sd0);
    queue_vector(KIND_FRAME, C_MAX, C_MIN, 32'sd1);
    queue_vector(KIND_INVERSE, C_MIN, C_MAX, -32'sd1);
    queue_vector(KIND_INVERSE, 32'sd1, -32'sd1, 32'sh0001_2345);
    wait_drained();

    // Every component at -2.0: conjugation must not wrap, and the norm of 16 saturates.
    set_attitude(C_MIN, C_MIN, C_MIN, C_MIN);
    queue_vector(KIND_FRAME, C_MAX, C_MIN, C_MAX);
    queue_vector(KIND_INVERSE, C_MAX, C_MIN, C_MAX);
    queue_vector(KIND_FRAME, 32'sd1, 32'sd2, 32'sd3);
    queue_vector(KIND_INVERSE, 32'sd1, 32'sd2, 32'sd3);
    wait_drained();

    // A zero quaternion gives a zero vector whatever the input.
    set_attitude(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    queue_vector(KIND_FRAME, C_MAX, C_MAX, C_MAX);
    queue_vector(KIND_INVERSE, C_MIN, C_MIN, C_MIN);
    wait_drained();

    set_attitude(C_MAX, C_MAX, C_MAX, C_MAX);
    queue_vector(KIND_FRAME, C_MIN, C_MIN, C_MIN);
    queue_vector(KIND_INVERSE, C_MIN, C_MIN, C_MIN);
    queue_vector(KIND_FRAME, -32'sd1, -32'sd1, -32'sd1);
    wait_drained();

    // Quarter turn about z.
    set_attitude(32'sd0, 32'sd0, 32'sh2D41_3CCD, 32'sh2D41_3CCD);
    queue_vector(KIND_FRAME, 32'sd32768, 32'sd0, 32'sd0);
    queue_vector(KIND_INVERSE, 32'sd32768, 32'sd0, 32'sd0);
    wait_drained();

    for (int phase = 0; phase < 10; phase++) begin
      style = phase % 4;
      set_attitude(random_quat_comp(style), random_quat_comp(style),
                   random_quat_comp(style), random_quat_comp(style));
      if (phase == 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: send_idle_pct = 0;
          1: send_idle_pct = 15;
          2: send_idle_pct = 35;
          default: send_idle_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 15;
          2: recv_idle_pct = 35;
          default: recv_idle_pct = 60;
        endcase
      end
      for (int n = 0; n < 175; n++)
        queue_vector($urandom_range(0, 1) ? KIND_INVERSE : KIND_FRAME,
                     random_vec_comp(), random_vec_comp(), random_vec_comp());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && rotations_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
